[hdl/stfg_pkg.sv]
// Shared types and constants for the staggered trilinear field gather.
// Holds the sequencer states, step codes, grid and stencil codes, and fixed-point constants.
// No dependencies.
`default_nettype none
package stfg_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      KIND_YZ,
      KIND_Y1Z1,
      KIND_Y1Z,
      KIND_YZ1
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] step;
   } mul_tag_type;

   localparam int NUM_GRIDS = 6;
   localparam int NUM_REGS  = 6;
   localparam int WORD_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int CELL_W    = 4;
   localparam int FACTOR_W  = 17;
   localparam int PAIR_W    = 33;
   localparam int WEIGHT_W  = 25;
   localparam int MUL_A_W   = 35;
   localparam int MUL_B_W   = 26;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 58;
   localparam int VAL_W     = ACC_W - 24;
   localparam int SUM_W     = 36;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_INTERP = 1'b1;

   localparam logic [2:0] GRID_EX = 3'd0;
   localparam logic [2:0] GRID_BX = 3'd1;
   localparam logic [2:0] GRID_PR = 3'd2;
   localparam logic [2:0] GRID_PL = 3'd3;
   localparam logic [2:0] GRID_SR = 3'd4;
   localparam logic [2:0] GRID_SL = 3'd5;

   localparam logic [2:0] REG_BIAS_EX = 3'd0;
   localparam logic [2:0] REG_BIAS_EY = 3'd1;
   localparam logic [2:0] REG_BIAS_EZ = 3'd2;
   localparam logic [2:0] REG_BIAS_BX = 3'd3;
   localparam logic [2:0] REG_BIAS_BY = 3'd4;
   localparam logic [2:0] REG_BIAS_BZ = 3'd5;

   localparam logic [3:0] STEP_XY0    = 4'd0;
   localparam logic [3:0] STEP_XY1    = 4'd1;
   localparam logic [3:0] STEP_W_YZ   = 4'd2;
   localparam logic [3:0] STEP_W_Y1Z1 = 4'd3;
   localparam logic [3:0] STEP_W_Y1Z  = 4'd4;
   localparam logic [3:0] STEP_W_YZ1  = 4'd5;
   localparam logic [3:0] STEP_ACC0   = 4'd6;
   localparam logic [3:0] STEP_LAST   = 4'd11;

   localparam logic [2:0] CORNER_LAST = 3'd7;

   localparam logic [FACTOR_W-1:0] ONE_Q16     = 17'h1_0000;
   localparam logic [48:0]         WEIGHT_HALF = 49'h80_0000;
   localparam logic [ACC_W-1:0]    ACC_HALF    = 58'h80_0000;

   localparam logic signed [SUM_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -36'sh0_8000_0000;

   function automatic kind_type grid_kind(input logic [2:0] grid);
      kind_type kind;
      unique case (grid)
         GRID_EX:          kind = KIND_YZ;
         GRID_BX:          kind = KIND_Y1Z1;
         GRID_PR, GRID_PL: kind = KIND_Y1Z;
         default:          kind = KIND_YZ1;
      endcase
      return kind;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[WORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/staggered_trilinear_field_gather.sv]
// Staggered trilinear field gather: six field grids and the interpolation sequencer.
// Depends on stfg_pkg, stfg_mem and stfg_mul.
//
// Requests enter on req_* (valid/stall). A write request (cmd 0) stores one grid word in
// the cycle it is accepted and gives no response. An interpolate request (cmd 1) gives one
// response on rsp_* (valid/stall): the six gathered fields plus their biases, saturated.
// Each interpolation walks the eight stencil corners; per corner the shared multiplier runs
// twelve steps (two x*y factor products, four corner weights, six word*weight products);
// an out-of-range request skips the corners and goes straight to the response stage.
// The multiplier is the one unit that bounds throughput.
// req_stall is high while a request is in work or its response cannot be loaded.
// A response is held in the output register until taken; while an earlier response is
// held under rsp_stall, a finished request waits, and no further request is accepted meanwhile.
// Bias registers on csr_* are written with csr_we; the user must do so only while the
// block is idle, as the block itself does not enforce it. Reset clears the sequencer, the
// response valid and the biases; grid contents are undefined until written.
`default_nettype none
module staggered_trilinear_field_gather #(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [2:0]  req_grid_sel,
   input  wire logic [3:0]  req_cell_i,
   input  wire logic [3:0]  req_cell_j,
   input  wire logic [3:0]  req_cell_k,
   input  wire logic [15:0] req_frac_x,
   input  wire logic [15:0] req_frac_y,
   input  wire logic [15:0] req_frac_z,
   input  wire logic signed [31:0] req_write_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_out_ex,
   output logic signed [31:0] rsp_out_ey,
   output logic signed [31:0] rsp_out_ez,
   output logic signed [31:0] rsp_out_bx,
   output logic signed [31:0] rsp_out_by,
   output logic signed [31:0] rsp_out_bz,
   output logic             rsp_out_of_range
);
   import stfg_pkg::*;

   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(CELLS);

   function automatic logic [AW-1:0] cell_addr(input logic [CELL_W:0] x,
                                               input logic [CELL_W:0] y,
                                               input logic [CELL_W:0] z);
      logic [AW-1:0] r;
      r = (AW'(x) * AW'(GRID_Y) + AW'(y)) * AW'(GRID_Z) + AW'(z);
      return r;
   endfunction

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  corner_ff, corner_in;

   logic [CELL_W-1:0] ci_ff, cj_ff, ck_ff, cjs_ff, cks_ff;
   logic [FRAC_W-1:0] fx_ff, fy_ff, fz_ff;
   logic              oor_ff;

   logic [PAIR_W-1:0]          pxy0_ff, pxy1_ff;
   logic [WEIGHT_W-1:0]        w_ff [4];
   logic signed [ACC_W-1:0]    acc_ff [NUM_GRIDS];
   logic signed [WORD_W-1:0]   bias_ff [NUM_REGS];

   logic rsp_valid_ff;
   logic signed [WORD_W-1:0] out_ff [NUM_GRIDS];
   logic out_oor_ff;

   logic req_accept, is_interp, range_ok, load_out;
   logic [CELL_W-1:0] js_w, ks_w;

   mul_tag_type               mul_tag, mul_tag_q;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_q;

   logic [FACTOR_W-1:0] wx, wy, wy1, wz, wz1;
   logic [FRAC_W-1:0]   fy1, fz1;
   logic [AW-1:0]       kind_addr [4];
   logic [AW-1:0]       waddr;
   logic                wr_in_grid;
   logic [31:0]         rdata [NUM_GRIDS];
   logic [2:0]          acc_sel, tag_sel;
   logic [48:0]         weight_sum;
   logic signed [VAL_W-1:0] val [NUM_GRIDS];
   logic signed [SUM_W-1:0] sum [NUM_GRIDS];

   // handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_interp  = (req_cmd == CMD_INTERP);
   assign load_out   = (state_ff == ST_FINAL) && (!rsp_valid_ff || !rsp_stall);

   assign js_w = req_frac_y[FRAC_W-1] ? req_cell_j : req_cell_j - 4'd1;
   assign ks_w = req_frac_z[FRAC_W-1] ? req_cell_k : req_cell_k - 4'd1;
   assign range_ok = (int'(req_cell_i) + 1 < GRID_X) &&
                     (int'(req_cell_j) + 1 < GRID_Y) &&
                     (int'(req_cell_k) + 1 < GRID_Z) &&
                     !(!req_frac_y[FRAC_W-1] && req_cell_j == '0) &&
                     !(!req_frac_z[FRAC_W-1] && req_cell_k == '0);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in   = '0;
            corner_in = '0;
            if (req_accept && is_interp) begin
               state_in = range_ok ? ST_RUN : ST_FINAL;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               if (corner_ff == CORNER_LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  corner_in = corner_ff + 3'd1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DRAIN: state_in = ST_FINAL;
         ST_FINAL: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept && is_interp) begin
         ci_ff  <= req_cell_i;
         cj_ff  <= req_cell_j;
         ck_ff  <= req_cell_k;
         cjs_ff <= js_w;
         cks_ff <= ks_w;
         fx_ff  <= req_frac_x;
         fy_ff  <= req_frac_y;
         fz_ff  <= req_frac_z;
         oor_ff <= !range_ok;
      end
   end

   // axis factors of the current corner
   assign fy1 = {~fy_ff[FRAC_W-1], fy_ff[FRAC_W-2:0]};
   assign fz1 = {~fz_ff[FRAC_W-1], fz_ff[FRAC_W-2:0]};
   assign wx  = corner_ff[0] ? {1'b0, fx_ff} : ONE_Q16 - {1'b0, fx_ff};
   assign wy  = corner_ff[1] ? {1'b0, fy_ff} : ONE_Q16 - {1'b0, fy_ff};
   assign wy1 = corner_ff[1] ? {1'b0, fy1}   : ONE_Q16 - {1'b0, fy1};
   assign wz  = corner_ff[2] ? {1'b0, fz_ff} : ONE_Q16 - {1'b0, fz_ff};
   assign wz1 = corner_ff[2] ? {1'b0, fz1}   : ONE_Q16 - {1'b0, fz1};

   // corner addresses per stencil kind
   always_comb begin
      logic [CELL_W:0] xi, yj, yjs, zk, zks;
      xi  = {1'b0, ci_ff}  + (CELL_W+1)'(corner_ff[0]);
      yj  = {1'b0, cj_ff}  + (CELL_W+1)'(corner_ff[1]);
      yjs = {1'b0, cjs_ff} + (CELL_W+1)'(corner_ff[1]);
      zk  = {1'b0, ck_ff}  + (CELL_W+1)'(corner_ff[2]);
      zks = {1'b0, cks_ff} + (CELL_W+1)'(corner_ff[2]);
      kind_addr[KIND_YZ]   = cell_addr(xi, yj, zk);
      kind_addr[KIND_Y1Z1] = cell_addr(xi, yjs, zks);
      kind_addr[KIND_Y1Z]  = cell_addr(xi, yjs, zk);
      kind_addr[KIND_YZ1]  = cell_addr(xi, yj, zks);
   end

   // grid stores
   assign waddr = cell_addr({1'b0, req_cell_i}, {1'b0, req_cell_j}, {1'b0, req_cell_k});
   assign wr_in_grid = (int'(req_cell_i) < GRID_X) && (int'(req_cell_j) < GRID_Y) &&
                       (int'(req_cell_k) < GRID_Z);

   for (genvar g = 0; g < NUM_GRIDS; g++) begin : g_grid
      stfg_mem #(
         .DEPTH (CELLS),
         .AW    (AW)
      ) u_mem (
         .clock (clock),
         .we    (req_accept && !is_interp && wr_in_grid && req_grid_sel == 3'(g)),
         .waddr (waddr),
         .wdata (req_write_value),
         .raddr (kind_addr[grid_kind(3'(g))]),
         .rdata (rdata[g])
      );
   end

   // shared multiplier operands
   assign acc_sel = 3'(step_ff - STEP_ACC0);

   always_comb begin
      mul_tag.valid = (state_ff == ST_RUN);
      mul_tag.step  = step_ff;
      unique case (step_ff)
         STEP_XY0: begin
            mul_a = $signed({18'd0, wx});
            mul_b = $signed({9'd0, wy});
         end
         STEP_XY1: begin
            mul_a = $signed({18'd0, wx});
            mul_b = $signed({9'd0, wy1});
         end
         STEP_W_YZ: begin
            mul_a = $signed({2'd0, pxy0_ff});
            mul_b = $signed({9'd0, wz});
         end
         STEP_W_Y1Z1: begin
            mul_a = $signed({2'd0, pxy1_ff});
            mul_b = $signed({9'd0, wz1});
         end
         STEP_W_Y1Z: begin
            mul_a = $signed({2'd0, pxy1_ff});
            mul_b = $signed({9'd0, wz});
         end
         STEP_W_YZ1: begin
            mul_a = $signed({2'd0, pxy0_ff});
            mul_b = $signed({9'd0, wz1});
         end
         default: begin
            mul_a = $signed({{3{rdata[acc_sel][31]}}, rdata[acc_sel]});
            mul_b = $signed({1'b0, w_ff[grid_kind(acc_sel)]});
         end
      endcase
   end

   stfg_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .tag    (mul_tag),
      .a      (mul_a),
      .b      (mul_b),
      .tag_q  (mul_tag_q),
      .prod_q (prod_q)
   );

   // product write-back
   assign tag_sel    = 3'(mul_tag_q.step - STEP_ACC0);
   assign weight_sum = prod_q[48:0] + WEIGHT_HALF;

   always_ff @(posedge clock) begin
      if (req_accept && is_interp) begin
         for (int g = 0; g < NUM_GRIDS; g++) begin
            acc_ff[g] <= '0;
         end
      end else if (mul_tag_q.valid) begin
         unique case (mul_tag_q.step)
            STEP_XY0:    pxy0_ff <= prod_q[PAIR_W-1:0];
            STEP_XY1:    pxy1_ff <= prod_q[PAIR_W-1:0];
            STEP_W_YZ:   w_ff[KIND_YZ]   <= weight_sum[48:24];
            STEP_W_Y1Z1: w_ff[KIND_Y1Z1] <= weight_sum[48:24];
            STEP_W_Y1Z:  w_ff[KIND_Y1Z]  <= weight_sum[48:24];
            STEP_W_YZ1:  w_ff[KIND_YZ1]  <= weight_sum[48:24];
            default:     acc_ff[tag_sel] <= acc_ff[tag_sel] + prod_q[ACC_W-1:0];
         endcase
      end
   end

   // bias registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            bias_ff[r] <= '0;
         end
      end else if (csr_we && int'(csr_index) < NUM_REGS) begin
         bias_ff[csr_index] <= csr_wdata;
      end
   end

   // round and combine; saturation is applied when the response register loads
   always_comb begin
      logic signed [ACC_W-1:0] rounded;
      for (int g = 0; g < NUM_GRIDS; g++) begin
         rounded = acc_ff[g] + ACC_HALF;
         val[g]  = rounded[ACC_W-1:24];
      end
      sum[GRID_EX] = SUM_W'(val[GRID_EX]) + SUM_W'(bias_ff[REG_BIAS_EX]);
      sum[GRID_BX] = SUM_W'(val[GRID_PR]) + SUM_W'(val[GRID_PL]) + SUM_W'(bias_ff[REG_BIAS_EY]);
      sum[GRID_PR] = SUM_W'(val[GRID_SR]) + SUM_W'(val[GRID_SL]) + SUM_W'(bias_ff[REG_BIAS_EZ]);
      sum[GRID_PL] = SUM_W'(val[GRID_BX]) + SUM_W'(bias_ff[REG_BIAS_BX]);
      sum[GRID_SR] = SUM_W'(val[GRID_SL]) - SUM_W'(val[GRID_SR]) + SUM_W'(bias_ff[REG_BIAS_BY]);
      sum[GRID_SL] = SUM_W'(val[GRID_PR]) - SUM_W'(val[GRID_PL]) + SUM_W'(bias_ff[REG_BIAS_BZ]);
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int g = 0; g < NUM_GRIDS; g++) begin
            out_ff[g] <= oor_ff ? '0 : sat_word(sum[g]);
         end
         out_oor_ff <= oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_ex       = out_ff[0];
   assign rsp_out_ey       = out_ff[1];
   assign rsp_out_ez       = out_ff[2];
   assign rsp_out_bx       = out_ff[3];
   assign rsp_out_by       = out_ff[4];
   assign rsp_out_bz       = out_ff[5];
   assign rsp_out_of_range = out_oor_ff;

endmodule
`default_nettype wire

[hdl/stfg_mem.sv]
// One field grid store: a single-port-write, single-port-read memory.
// Read data is registered. Depends on nothing outside this file.
`default_nettype none
module stfg_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [31:0]   wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [31:0]   rdata
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

[hdl/stfg_mul.sv]
// Shared signed multiplier with registered product and step tag.
// Depends on stfg_pkg.
`default_nettype none
module stfg_mul (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire stfg_pkg::mul_tag_type                 tag,
   input  wire logic signed [stfg_pkg::MUL_A_W-1:0]   a,
   input  wire logic signed [stfg_pkg::MUL_B_W-1:0]   b,
   output stfg_pkg::mul_tag_type                      tag_q,
   output logic signed [stfg_pkg::PROD_W-1:0]         prod_q
);
   import stfg_pkg::*;

   mul_tag_type              tag_ff;
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(a) * PROD_W'(b);
   end

   assign tag_q  = tag_ff;
   assign prod_q = prod_ff;

endmodule
`default_nettype wire

[bench/staggered_trilinear_field_gather_tb.sv]
// Self-checking testbench for the staggered trilinear field gather.
// Preloads two corner blocks of each grid, then runs directed and random requests with a predictor.
// Depends on stfg_pkg and staggered_trilinear_field_gather.
`default_nettype none
module staggered_trilinear_field_gather_tb;
   import stfg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        cmd;
      logic [2:0]  sel;
      logic [3:0]  ci, cj, ck;
      logic [15:0] fx, fy, fz;
      logic [31:0] wv;
   } field_req_type;

   typedef struct {
      logic signed [31:0] ex, ey, ez, bx, by, bz;
      logic               oor;
   } field_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic [2:0] req_grid_sel = '0;
   logic [3:0] req_cell_i = '0, req_cell_j = '0, req_cell_k = '0;
   logic [15:0] req_frac_x = '0, req_frac_y = '0, req_frac_z = '0;
   logic signed [31:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_ex, rsp_out_ey, rsp_out_ez, rsp_out_bx, rsp_out_by, rsp_out_bz;
   logic rsp_out_of_range;

   staggered_trilinear_field_gather u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   field_req_type pending_reqs[$];
   field_rsp_type expected_fields[$];
   logic signed [31:0] grid_model[NUM_GRIDS][4096];
   longint bias_model[NUM_REGS];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int hold_done = 0;
   int hold_cnt = 0;
   int fail_count = 0;
   logic req_fire = 1'b0;

   function automatic longint gather_grid(int g, int i0, int j0, int k0,
                                          longint fx, longint fy, longint fz);
      longint acc, w, wx, wy, wz;
      int c, a;
      acc = 0;
      for (c = 0; c < 8; c++) begin
         wx = c[0] ? fx : 65536 - fx;
         wy = c[1] ? fy : 65536 - fy;
         wz = c[2] ? fz : 65536 - fz;
         w = (wx * wy * wz + (64'sd1 << 23)) >>> 24;
         a = ((i0 + c[0]) * 16 + (j0 + c[1])) * 16 + (k0 + c[2]);
         acc += longint'(grid_model[g][a]) * w;
      end
      return (acc + (64'sd1 << 23)) >>> 24;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic field_rsp_type gather_fields(field_req_type r);
      field_rsp_type e;
      int i, j, k, js, ks;
      longint fy1, fz1, ex, bx, pr, pl, sr, sl;
      i = r.ci; j = r.cj; k = r.ck;
      js = r.fy >= 16'h8000 ? j : j - 1;
      ks = r.fz >= 16'h8000 ? k : k - 1;
      fy1 = r.fy >= 16'h8000 ? r.fy - 32768 : r.fy + 32768;
      fz1 = r.fz >= 16'h8000 ? r.fz - 32768 : r.fz + 32768;
      e = '{default: '0};
      if (i > 14 || j > 14 || k > 14 || js < 0 || ks < 0) begin
         e.oor = 1'b1;
         return e;
      end
      ex = gather_grid(GRID_EX, i, j, k, r.fx, r.fy, r.fz);
      bx = gather_grid(GRID_BX, i, js, ks, r.fx, fy1, fz1);
      pr = gather_grid(GRID_PR, i, js, k, r.fx, fy1, r.fz);
      pl = gather_grid(GRID_PL, i, js, k, r.fx, fy1, r.fz);
      sr = gather_grid(GRID_SR, i, j, ks, r.fx, r.fy, fz1);
      sl = gather_grid(GRID_SL, i, j, ks, r.fx, r.fy, fz1);
      e.ex = clamp32(ex + bias_model[REG_BIAS_EX]);
      e.ey = clamp32(pr + pl + bias_model[REG_BIAS_EY]);
      e.ez = clamp32(sr + sl + bias_model[REG_BIAS_EZ]);
      e.bx = clamp32(bx + bias_model[REG_BIAS_BX]);
      e.by = clamp32(sl - sr + bias_model[REG_BIAS_BY]);
      e.bz = clamp32(pr - pl + bias_model[REG_BIAS_BZ]);
      return e;
   endfunction

   // accept, predict and check at the rising edge
   always @(posedge clock) begin : watch_ports
      field_req_type r;
      field_rsp_type e;
      req_fire = req_valid && !req_stall && !reset;
      if (req_fire) begin
         r = '{req_cmd, req_grid_sel, req_cell_i, req_cell_j, req_cell_k,
               req_frac_x, req_frac_y, req_frac_z, req_write_value};
         if (r.cmd == CMD_WRITE) begin
            if (r.sel < NUM_GRIDS)
               grid_model[r.sel][{r.ci, r.cj, r.ck}] = r.wv;
         end else begin
            expected_fields.push_back(gather_fields(r));
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fields.size() == 0) begin
            $error("response with nothing expected");
            fail_count++;
         end else begin
            e = expected_fields.pop_front();
            if (rsp_out_ex !== e.ex) begin
               $error("out_ex expected %0d got %0d", e.ex, rsp_out_ex); fail_count++;
            end
            if (rsp_out_ey !== e.ey) begin
               $error("out_ey expected %0d got %0d", e.ey, rsp_out_ey); fail_count++;
            end
            if (rsp_out_ez !== e.ez) begin
               $error("out_ez expected %0d got %0d", e.ez, rsp_out_ez); fail_count++;
            end
            if (rsp_out_bx !== e.bx) begin
               $error("out_bx expected %0d got %0d", e.bx, rsp_out_bx); fail_count++;
            end
            if (rsp_out_by !== e.by) begin
               $error("out_by expected %0d got %0d", e.by, rsp_out_by); fail_count++;
            end
            if (rsp_out_bz !== e.bz) begin
               $error("out_bz expected %0d got %0d", e.bz, rsp_out_bz); fail_count++;
            end
            if (rsp_out_of_range !== e.oor) begin
               $error("out_of_range expected %0d got %0d", e.oor, rsp_out_of_range);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin : drive_req
      field_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_cmd <= nxt.cmd;
            req_grid_sel <= nxt.sel;
            req_cell_i <= nxt.ci;
            req_cell_j <= nxt.cj;
            req_cell_k <= nxt.ck;
            req_frac_x <= nxt.fx;
            req_frac_y <= nxt.fy;
            req_frac_z <= nxt.fz;
            req_write_value <= nxt.wv;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hold the response side off for a long stretch when asked
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_asks != hold_done) begin
         rsp_stall <= 1'b1;
         hold_cnt <= 600;
         hold_done <= hold_asks;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   function automatic logic [15:0] pick_frac();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // in-range stencils stay inside the preloaded block of cells 0..3
   function automatic field_req_type make_request();
      field_req_type r;
      r.cmd = $urandom_range(1) ? CMD_INTERP : CMD_WRITE;
      r.sel = 3'($urandom_range(7));
      r.fx = pick_frac();
      r.fy = pick_frac();
      r.fz = pick_frac();
      r.wv = pick_word();
      if (r.cmd == CMD_WRITE) begin
         if ($urandom_range(1)) begin
            r.ci = 4'($urandom_range(3));
            r.cj = 4'($urandom_range(3));
            r.ck = 4'($urandom_range(3));
         end else begin
            r.ci = 4'($urandom);
            r.cj = 4'($urandom);
            r.ck = 4'($urandom);
         end
      end else if ($urandom_range(9) != 0) begin
         r.ci = 4'($urandom_range(2));
         r.cj = 4'($urandom_range(2, 1));
         r.ck = 4'($urandom_range(2, 1));
      end else begin
         r.ci = 4'($urandom);
         r.cj = 4'($urandom);
         r.ck = 4'($urandom);
         case ($urandom_range(4))
            0: r.ci = 4'd15;
            1: r.cj = 4'd15;
            2: r.ck = 4'd15;
            3: begin
               r.cj = 4'd0;
               r.fy[15] = 1'b0;
            end
            default: begin
               r.ck = 4'd0;
               r.fz[15] = 1'b0;
            end
         endcase
      end
      return r;
   endfunction

   function automatic field_req_type interp_at(int i, int j, int k, int fx, int fy, int fz);
      return '{CMD_INTERP, GRID_EX, 4'(i), 4'(j), 4'(k), 16'(fx), 16'(fy), 16'(fz), '0};
   endfunction

   function automatic field_req_type write_at(logic [2:0] g, int i, int j, int k,
                                              logic [31:0] v);
      return '{CMD_WRITE, g, 4'(i), 4'(j), 4'(k), '0, '0, '0, v};
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_fields.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_biases(logic [31:0] v0, v1, v2, v3, v4, v5);
      logic [31:0] vals[NUM_REGS];
      vals = '{v0, v1, v2, v3, v4, v5};
      for (int n = 0; n < NUM_REGS; n++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= 3'(n);
         csr_wdata <= vals[n];
         bias_model[n] = longint'(signed'(vals[n]));
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n, int send_pct, int rsp_pct, bit long_hold);
      send_idle_pct = send_pct;
      stall_pct = rsp_pct;
      for (int m = 0; m < n; m++)
         pending_reqs.push_back(make_request());
      if (long_hold) hold_asks++;
      drain();
   endtask

   initial begin
      for (int n = 0; n < NUM_REGS; n++) bias_model[n] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_biases('0, '0, '0, '0, '0, '0);
      for (int g = 0; g < NUM_GRIDS; g++) begin
         for (int a = 0; a < 64; a++)
            pending_reqs.push_back(write_at(3'(g), a / 16, (a / 4) % 4, a % 4, pick_word()));
         for (int a = 0; a < 8; a++)
            pending_reqs.push_back(write_at(3'(g), 14 + a / 4, 14 + (a / 2) % 2, 14 + a % 2,
                                            pick_word()));
      end
      drain();

      pending_reqs.push_back(write_at(3'd6, 2, 2, 2, 32'h1234_5678));
      pending_reqs.push_back(write_at(3'd7, 2, 2, 2, 32'h8765_4321));
      pending_reqs.push_back(write_at(GRID_EX, 1, 1, 1, 32'h7FFF_FFFF));
      pending_reqs.push_back(write_at(GRID_PR, 1, 1, 1, 32'h7FFF_FFFF));
      pending_reqs.push_back(write_at(GRID_PL, 1, 1, 1, 32'h7FFF_FFFF));
      pending_reqs.push_back(write_at(GRID_SR, 1, 1, 1, 32'h8000_0000));
      pending_reqs.push_back(write_at(GRID_SL, 1, 1, 1, 32'h7FFF_FFFF));
      pending_reqs.push_back(interp_at(1, 1, 1, 0, 'h8000, 'h8000));
      pending_reqs.push_back(interp_at(2, 2, 2, 0, 0, 0));
      pending_reqs.push_back(interp_at(0, 0, 2, 'h1000, 'h7FFF, 'h9000));
      pending_reqs.push_back(interp_at(0, 0, 2, 'h1000, 'h8000, 'h9000));
      pending_reqs.push_back(interp_at(2, 2, 0, 'hFFFF, 'h9000, 'h7FFF));
      pending_reqs.push_back(interp_at(2, 2, 0, 'hFFFF, 'h9000, 'h8000));
      pending_reqs.push_back(interp_at(14, 14, 14, 'hFFFF, 'hFFFF, 'hFFFF));
      pending_reqs.push_back(interp_at(15, 5, 5, 'h4000, 'hC000, 'hC000));
      pending_reqs.push_back(interp_at(5, 15, 5, 'h4000, 'h2000, 'hC000));
      pending_reqs.push_back(interp_at(5, 5, 15, 'h4000, 'hC000, 'h2000));
      pending_reqs.push_back(interp_at(0, 1, 1, 0, 0, 0));
      pending_reqs.push_back(interp_at(1, 2, 1, 'hFFFF, 'h0001, 'h8001));
      drain();

      random_phase(300, 0, 0, 1'b1);
      set_biases(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_phase(300, 75, 0, 1'b0);
      set_biases(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      random_phase(300, 0, 75, 1'b0);
      set_biases($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(300, 11, 11, 1'b1);

      if (fail_count == 0) begin
         $display("[staggered_trilinear_field_gather] OK");
      end else begin
         $display("[staggered_trilinear_field_gather] ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[staggered_trilinear_field_gather] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
